// ----- rtl/core/ssm_pkg.sv -----
// Shared types, constants and segment lookup for the seven-segment multiplexer.
`default_nettype none
package ssm_pkg;

    localparam int VALUE_W   = 10;
    localparam int PATTERN_W = 8;
    localparam int POS_W     = 2;
    localparam int DIGIT_W   = 4;
    localparam int COUNT_W   = 8;
    localparam int MASK_W    = 3;
    localparam int CFG_IDX_W = 8;
    localparam int CFG_DAT_W = 8;
    localparam int S_DATA_W  = 16;
    localparam int M_DATA_W  = 16;

    localparam logic [VALUE_W-1:0]   VALUE_MAX         = 10'd999;
    localparam logic [PATTERN_W-1:0] BLANK_PATTERN     = 8'hFD;
    localparam logic [PATTERN_W-1:0] POINT_BIT         = 8'h02;
    localparam logic [COUNT_W-1:0]   HALF_PERIOD_RESET = 8'd70;

    localparam logic [POS_W-1:0] POS_UNITS    = 2'd0;
    localparam logic [POS_W-1:0] POS_TENS     = 2'd1;
    localparam logic [POS_W-1:0] POS_HUNDREDS = 2'd2;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_POINT_MASK   = 8'd0;
    localparam logic [CFG_IDX_W-1:0] REG_BLINK_ENABLE = 8'd1;
    localparam logic [CFG_IDX_W-1:0] REG_BLINK_HALF   = 8'd2;

    typedef struct packed {
        logic [MASK_W-1:0]  point_mask;
        logic               blink_enable;
        logic [COUNT_W-1:0] blink_half_period;
    } cfg_t;

    typedef struct packed {
        logic               blanked;
        logic [POS_W-1:0]   digit_position;
        logic [PATTERN_W-1:0] segment_pattern;
    } res_t;

    // Active-low segment glyphs for 0..9
    function automatic logic [PATTERN_W-1:0] seg_lookup(input logic [DIGIT_W-1:0] digit);
        logic [PATTERN_W-1:0] pat;
        begin
            case (digit)
                4'd0:    pat = 8'h0A;
                4'd1:    pat = 8'h7B;
                4'd2:    pat = 8'h26;
                4'd3:    pat = 8'h62;
                4'd4:    pat = 8'h53;
                4'd5:    pat = 8'hC2;
                4'd6:    pat = 8'h82;
                4'd7:    pat = 8'h6B;
                4'd8:    pat = 8'h02;
                4'd9:    pat = 8'h42;
                default: pat = BLANK_PATTERN;
            endcase
            return pat;
        end
    endfunction

endpackage
`default_nettype wire

// ----- rtl/core/seven_segment_mux_with_blink.sv -----
// Top level: three-digit seven-segment scan multiplexer with blink.
// An accepted word is registered in the output register, or in the skid entry on a stall.
// One word per cycle unless m_tready stalls. A skid entry takes one extra word while
// m_tready is low; s_tready then stays low until the cycle after m_tready takes it.
// Reset (aresetn low, synchronous): scan at units, blink counter zero and rising,
// point_mask 0, blink_enable 0, blink_half_period 70, output and skid empty.
`default_nettype none
module seven_segment_mux_with_blink
    import ssm_pkg::*;
(
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    // Input words
    input  wire logic                 s_tvalid,
    output logic                      s_tready,
    input  wire logic [S_DATA_W-1:0]  s_tdata,   // [9:0] shown_value, rest zero
    // Result words
    output logic                      m_tvalid,
    input  wire logic                 m_tready,
    output logic [M_DATA_W-1:0]       m_tdata,   // [7:0] segment_pattern,
                                                 // [9:8] digit_position, [10] blanked
    // Register writes
    input  wire logic                 cfg_valid,
    output logic                      cfg_ready,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [CFG_DAT_W-1:0] cfg_data
);

    cfg_t cfg_reg, cfg_next;
    logic tick;
    logic blank;
    res_t result;
    res_t out_word;

    // Register writes always complete; unknown indexes are dropped.
    assign cfg_ready = 1'b1;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_valid) begin
            case (cfg_index)
                REG_POINT_MASK:   cfg_next.point_mask        = cfg_data[MASK_W-1:0];
                REG_BLINK_ENABLE: cfg_next.blink_enable      = cfg_data[0];
                REG_BLINK_HALF:   cfg_next.blink_half_period = cfg_data[COUNT_W-1:0];
                default:          cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.point_mask        <= '0;
            cfg_reg.blink_enable      <= 1'b0;
            cfg_reg.blink_half_period <= HALF_PERIOD_RESET;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    // One refresh tick per accepted word; scan and blink state step on it.
    assign tick = s_tvalid && s_tready;

    ssm_blink u_blink (
        .aclk    (aclk),
        .aresetn (aresetn),
        .tick    (tick),
        .cfg     (cfg_reg),
        .blank   (blank)
    );

    ssm_scan u_scan (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .tick        (tick),
        .shown_value (s_tdata[VALUE_W-1:0]),
        .blank       (blank),
        .cfg         (cfg_reg),
        .result      (result)
    );

    ssm_skid u_skid (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_word   (result),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_word  (out_word)
    );

    assign m_tdata = {5'd0, out_word.blanked, out_word.digit_position,
                      out_word.segment_pattern};

    // A blanked word always carries the blank glyph with only the point bit free.
    a_blank_glyph: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[10] |-> (m_tdata[7:0] | POINT_BIT) == 8'hFF)
        else $error("blanked word shows a digit glyph");

    a_no_blank_when_off: assert property (@(posedge aclk) disable iff (!aresetn)
        tick && !cfg_reg.blink_enable |-> !blank)
        else $error("blanking while blink disabled");

endmodule
`default_nettype wire

// ----- rtl/core/ssm_blink.sv -----
// Triangle blink counter: rises to the half period, then falls with blanking.
`default_nettype none
module ssm_blink
    import ssm_pkg::*;
(
    input  wire logic aclk,
    input  wire logic aresetn,
    input  wire logic tick,
    input  wire cfg_t cfg,
    output logic      blank
);

    logic [COUNT_W-1:0] blink_count_reg, blink_count_next;
    logic               blink_falling_reg, blink_falling_next;

    always_comb begin
        blink_count_next   = blink_count_reg;
        blink_falling_next = blink_falling_reg;
        blank              = 1'b0;
        if (tick && cfg.blink_enable) begin
            if (!blink_falling_reg) begin
                if (blink_count_reg < cfg.blink_half_period) begin
                    blink_count_next = blink_count_reg + 1'b1;
                end else begin
                    blink_falling_next = 1'b1;
                    blank              = 1'b1;
                end
            end else if (blink_count_reg != '0) begin
                blink_count_next = blink_count_reg - 1'b1;
                blank            = 1'b1;
            end else begin
                blink_falling_next = 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            blink_count_reg   <= '0;
            blink_falling_reg <= 1'b0;
        end else begin
            blink_count_reg   <= blink_count_next;
            blink_falling_reg <= blink_falling_next;
        end
    end

    a_hold_when_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        !(tick && cfg.blink_enable) |=> $stable(blink_count_reg) && $stable(blink_falling_reg))
        else $error("blink state moved without an enabled tick");

    a_turn_rising: assert property (@(posedge aclk) disable iff (!aresetn)
        tick && cfg.blink_enable && blink_falling_reg && blink_count_reg == '0
        |=> !blink_falling_reg)
        else $error("falling phase did not end at zero");

endmodule
`default_nettype wire

// ----- rtl/core/ssm_scan.sv -----
// Scan position, digit split and segment pattern for one refresh word.
`default_nettype none
module ssm_scan
    import ssm_pkg::*;
(
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               tick,
    input  wire logic [VALUE_W-1:0] shown_value,
    input  wire logic               blank,
    input  wire cfg_t               cfg,
    output res_t                    result
);

    logic [POS_W-1:0]   scan_position_reg, scan_position_next;
    logic [VALUE_W-1:0] sat_value;
    logic [17:0]        prod10;
    logic [15:0]        prod100;
    logic [6:0]         quot10;
    logic [DIGIT_W-1:0] units, tens, hundreds, digit;
    logic [PATTERN_W-1:0] pattern;
    logic               point;

    always_comb begin
        sat_value = (shown_value > VALUE_MAX) ? VALUE_MAX : shown_value;
        // x/10 = (x*205)>>11 and x/100 = (x*41)>>12, exact up to 999
        prod10   = {8'd0, sat_value} * 18'd205;
        prod100  = {6'd0, sat_value} * 16'd41;
        quot10   = prod10[17:11];
        hundreds = prod100[15:12];
        units    = DIGIT_W'(sat_value - 10'(quot10) * 10'd10);
        tens     = DIGIT_W'(quot10 - 7'(hundreds) * 7'd10);

        case (scan_position_reg)
            POS_UNITS:    digit = units;
            POS_TENS:     digit = tens;
            POS_HUNDREDS: digit = hundreds;
            default:      digit = 4'hF;
        endcase

        pattern = blank ? BLANK_PATTERN : seg_lookup(digit);
        point   = (scan_position_reg == 2'd3) ? 1'b0 : cfg.point_mask[scan_position_reg];
        if (point) begin
            pattern = pattern & ~POINT_BIT;
        end else begin
            pattern = pattern | POINT_BIT;
        end

        result.segment_pattern = pattern;
        result.digit_position  = scan_position_reg;
        result.blanked         = blank;

        scan_position_next = scan_position_reg;
        if (tick) begin
            scan_position_next = (scan_position_reg >= POS_HUNDREDS) ? POS_UNITS
                                                                     : scan_position_reg + 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            scan_position_reg <= POS_UNITS;
        end else begin
            scan_position_reg <= scan_position_next;
        end
    end

    a_pos_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        scan_position_reg != 2'd3)
        else $error("scan position left 0..2");

    a_pos_advance: assert property (@(posedge aclk) disable iff (!aresetn)
        tick && scan_position_reg == POS_HUNDREDS |=> scan_position_reg == POS_UNITS)
        else $error("scan did not wrap after hundreds");

endmodule
`default_nettype wire

// ----- rtl/core/ssm_skid.sv -----
// Output register with a skid entry so the input side can take one more word while output stalls.
`default_nettype none
module ssm_skid
    import ssm_pkg::*;
(
    input  wire logic aclk,
    input  wire logic aresetn,
    input  wire logic in_valid,
    output logic      in_ready,
    input  wire res_t in_word,
    output logic      out_valid,
    input  wire logic out_ready,
    output res_t      out_word
);

    logic out_valid_reg, out_valid_next;
    logic skid_valid_reg, skid_valid_next;
    res_t out_word_reg, out_word_next;
    res_t skid_word_reg, skid_word_next;
    logic take_in;

    assign in_ready  = !skid_valid_reg;
    assign out_valid = out_valid_reg;
    assign out_word  = out_word_reg;
    assign take_in   = in_valid && in_ready;

    always_comb begin
        out_valid_next  = out_valid_reg;
        skid_valid_next = skid_valid_reg;
        out_word_next   = out_word_reg;
        skid_word_next  = skid_word_reg;
        if (!out_valid_reg || out_ready) begin
            if (skid_valid_reg) begin
                out_word_next   = skid_word_reg;
                out_valid_next  = 1'b1;
                skid_valid_next = 1'b0;
            end else begin
                out_word_next  = in_word;
                out_valid_next = take_in;
            end
        end else if (take_in) begin
            skid_word_next  = in_word;
            skid_valid_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
        out_word_reg  <= out_word_next;
        skid_word_reg <= skid_word_next;
    end

    a_skid_behind_out: assert property (@(posedge aclk) disable iff (!aresetn)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid entry held with empty output register");

    a_skid_fill: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(skid_valid_reg) |-> $past(out_valid_reg && !out_ready && in_valid))
        else $error("skid filled without a stalled output");

endmodule
`default_nettype wire

// ----- tb/sv/tb_seven_segment_mux_with_blink.sv -----
// Self-checking testbench for the three-digit seven-segment scan multiplexer with blink.
`default_nettype none
module tb_seven_segment_mux_with_blink;
    import ssm_pkg::*;

    localparam int          RUN_LIMIT    = 300000;  // cycles before the run is called hung
    localparam int          SETTLE_WAIT  = 4;       // room for the output register plus margin
    localparam int          RAND_PHASES  = 8;
    localparam int          PHASE_WORDS  = 166;
    // Indexes past the register list; writes there must be dropped.
    localparam logic [CFG_IDX_W-1:0] REG_NONE_LOW = 8'd3;
    localparam logic [CFG_IDX_W-1:0] REG_NONE_TOP = 8'hFF;

    logic                 aclk      = 1'b0;
    logic                 aresetn   = 1'b0;
    logic                 s_tvalid  = 1'b0;
    logic                 s_tready;
    logic [S_DATA_W-1:0]  s_tdata   = '0;
    logic                 m_tvalid;
    logic                 m_tready  = 1'b0;
    logic [M_DATA_W-1:0]  m_tdata;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [CFG_DAT_W-1:0] cfg_data  = '0;

    seven_segment_mux_with_blink u_top (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // Values waiting to be sent, and the display words they should produce.
    logic [VALUE_W-1:0] values_to_send [$];
    res_t               display_expect [$];
    int                 mismatches = 0;
    int                 cycles     = 0;
    logic               steady     = 1'b0;  // set for a stretch with no idling on either side

    // Shadow of the block's registers and scan/blink state.
    logic [MASK_W-1:0]  shadow_mask  = '0;
    logic               shadow_blink = 1'b0;
    logic [COUNT_W-1:0] shadow_half  = HALF_PERIOD_RESET;
    logic [POS_W-1:0]   scan_pos     = POS_UNITS;
    logic [COUNT_W-1:0] blink_cnt    = '0;
    logic               blink_down   = 1'b0;

    // Active-low glyphs for digits 0..9.
    logic [PATTERN_W-1:0] glyph [10] = '{8'h0A, 8'h7B, 8'h26, 8'h62, 8'h53,
                                         8'hC2, 8'h82, 8'h6B, 8'h02, 8'h42};

    // Per-phase settings for the random part; covers half period 0, 1 and 255.
    logic [COUNT_W-1:0] half_plan  [RAND_PHASES] = '{8'd255, 8'd5, 8'd1, 8'd0,
                                                      8'd70, 8'd2, 8'd128, 8'd17};
    logic               blink_plan [RAND_PHASES] = '{1'b1, 1'b1, 1'b1, 1'b1,
                                                      1'b0, 1'b1, 1'b1, 1'b1};

    // Work out the display word for one refresh tick and advance scan/blink state.
    function automatic res_t next_display(input logic [VALUE_W-1:0] raw);
        int                   v;
        int                   digit;
        logic                 blank;
        logic                 point;
        logic [PATTERN_W-1:0] pat;
        res_t                 r;
        v     = (raw > VALUE_MAX) ? 999 : int'(raw);
        blank = 1'b0;
        // Triangle counter: up while rising, blanked all the way down.
        if (shadow_blink) begin
            if (!blink_down) begin
                if (blink_cnt < shadow_half) begin
                    blink_cnt = blink_cnt + 8'd1;
                end else begin
                    blink_down = 1'b1;
                    blank      = 1'b1;
                end
            end else if (blink_cnt != '0) begin
                blink_cnt = blink_cnt - 8'd1;
                blank     = 1'b1;
            end else begin
                blink_down = 1'b0;
            end
        end
        case (scan_pos)
            POS_UNITS:    digit = v % 10;
            POS_TENS:     digit = (v / 10) % 10;
            POS_HUNDREDS: digit = v / 100;
            default:      digit = -1;
        endcase
        pat   = (blank || digit < 0) ? BLANK_PATTERN : glyph[digit];
        point = (scan_pos <= POS_HUNDREDS) ? shadow_mask[scan_pos] : 1'b0;
        pat   = point ? (pat & ~POINT_BIT) : (pat | POINT_BIT);
        r.segment_pattern = pat;
        r.digit_position  = scan_pos;
        r.blanked         = blank;
        scan_pos = (scan_pos >= POS_HUNDREDS) ? POS_UNITS : scan_pos + 2'd1;
        return r;
    endfunction

    // Driver: presents queued values, holds a word until it is taken.
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && s_tready)
                display_expect.push_back(next_display(s_tdata[VALUE_W-1:0]));
            if (!s_tvalid || s_tready) begin
                if (values_to_send.size() != 0 && (steady || $urandom_range(0, 99) >= 33)) begin
                    s_tdata  <= {{(S_DATA_W-VALUE_W){1'b0}}, values_to_send.pop_front()};
                    s_tvalid <= 1'b1;
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // Monitor: checks each accepted result word against the oldest expectation.
    always @(posedge aclk) begin
        res_t got;
        res_t want;
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                got = m_tdata[$bits(res_t)-1:0];
                if (display_expect.size() == 0) begin
                    $error("unexpected result word %h", m_tdata);
                    mismatches++;
                end else begin
                    want = display_expect.pop_front();
                    if (got.segment_pattern !== want.segment_pattern) begin
                        $error("segment_pattern: expected %h, got %h",
                               want.segment_pattern, got.segment_pattern);
                        mismatches++;
                    end
                    if (got.digit_position !== want.digit_position) begin
                        $error("digit_position: expected %0d, got %0d",
                               want.digit_position, got.digit_position);
                        mismatches++;
                    end
                    if (got.blanked !== want.blanked) begin
                        $error("blanked: expected %b, got %b", want.blanked, got.blanked);
                        mismatches++;
                    end
                end
            end
            m_tready <= steady || ($urandom_range(0, 99) >= 33);
        end
    end

    // Watchdog
    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles == RUN_LIMIT) begin
            $display("** seven_segment_mux_with_blink: FAILED **");
            $finish;
        end
    end

    // One register write; the shadow follows only at the accepting edge.
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DAT_W-1:0] val);
        @(posedge aclk);
        cfg_index <= idx;
        cfg_data  <= val;
        cfg_valid <= 1'b1;
        do @(posedge aclk); while (!cfg_ready);
        case (idx)
            REG_POINT_MASK:   shadow_mask  = val[MASK_W-1:0];
            REG_BLINK_ENABLE: shadow_blink = val[0];
            REG_BLINK_HALF:   shadow_half  = val;
            default: ;
        endcase
        cfg_valid <= 1'b0;
    endtask

    // Block until every queued word went in and every result came back.
    // Checked mid-cycle so the queues and s_tvalid have all settled.
    task automatic drain;
        do @(negedge aclk);
        while (values_to_send.size() != 0 || s_tvalid || display_expect.size() != 0);
        repeat (SETTLE_WAIT) @(posedge aclk);
    endtask

    initial begin
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Reset settings: no blink, no points. Digit extremes and saturation.
        values_to_send = '{10'd0, 10'd999, 10'd1000, 10'd1023, 10'd123, 10'd456,
                           10'd789, 10'd100, 10'd10, 10'd1, 10'd512, 10'd888};
        drain();

        // All points lit (upper data bits must be dropped), out-of-range indexes
        // ignored, blink with half period zero: blanks on every other tick.
        write_reg(REG_POINT_MASK, 8'hFF);
        write_reg(REG_NONE_LOW, 8'h00);
        write_reg(REG_NONE_TOP, 8'h55);
        write_reg(REG_BLINK_HALF, 8'd0);
        write_reg(REG_BLINK_ENABLE, 8'hFE);  // bit 0 clear: stays off
        write_reg(REG_BLINK_ENABLE, 8'h01);
        values_to_send = '{10'd321, 10'd654, 10'd987, 10'd1020};
        drain();

        // Count up a little, then drop the half period below the count.
        write_reg(REG_POINT_MASK, 8'd5);
        write_reg(REG_BLINK_HALF, 8'd3);
        values_to_send = '{10'd11, 10'd22, 10'd33};
        drain();
        write_reg(REG_BLINK_HALF, 8'd1);
        values_to_send = '{10'd44, 10'd55, 10'd66, 10'd77, 10'd999};
        drain();

        // Random part: blink state carries over between phases on purpose.
        for (int p = 0; p < RAND_PHASES; p++) begin
            case (p)
                0:       write_reg(REG_POINT_MASK, 8'd7);
                1:       write_reg(REG_POINT_MASK, 8'd0);
                default: write_reg(REG_POINT_MASK, 8'($urandom_range(0, 255)));
            endcase
            write_reg(REG_BLINK_ENABLE, {7'($urandom_range(0, 127)), blink_plan[p]});
            write_reg(REG_BLINK_HALF, half_plan[p]);
            steady = (p == 2);
            for (int i = 0; i < PHASE_WORDS; i++)
                values_to_send.push_back(10'($urandom_range(0, 1023)));
            drain();
        end
        steady = 1'b0;

        drain();
        if (mismatches == 0) begin
            $display("** seven_segment_mux_with_blink: PASSED **");
        end else begin
            $display("** seven_segment_mux_with_blink: FAILED **");
        end
        $finish;
    end

endmodule
`default_nettype wire
